// ===== rtl/core/sti_pkg.sv =====
// ----------------------------------------------------------------------------
// sti_pkg
// shared types and codes for the sorted table insert/remove block
// ----------------------------------------------------------------------------
package sti_pkg;

    // width of one stored value
    localparam int VALUE_W = 32;

    // operation codes carried in tuser
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_INSERTED  = 2'd0,
        STATUS_REMOVED   = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    // outcome of the shared compare unit
    typedef struct packed {
        logic gt;   // stored entry strictly above the operand
        logic eq;   // stored entry equal to the operand
    } cmp_res_t;

endpackage

// ===== rtl/core/sorted_table_insert_remove_top.sv =====
// sequence: an insert reads and moves entries up from the top until it places the value, a remove
//   reads every entry held; a refused insert skips the ram; S_DONE waits while the output stalls
// throughput: one item at a time; s_tready returns on the edge that registers the
//   result, set by the entry ram's one read port and one compare unit
// reset: rst_n asynchronous, active low; clears count, sequencer and output
//   valid; the entry ram is not cleared and only entries below count are read
// ----------------------------------------------------------------------------
// sorted_table_insert_remove_top
// bounded ascending table of signed values with insert and remove, scanned
// one entry per S_RD/S_CHK pair by a small sequencer around a shared comparator
// ----------------------------------------------------------------------------
module sorted_table_insert_remove_top #(
    parameter int CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    input  logic [0:0]  s_tuser,    // [0] action
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // [1:0] status, [7:2] entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam int VW = sti_pkg::VALUE_W;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // waiting for an item
        S_RD   = 4'b0010,   // issue ram read or finish the scan
        S_CHK  = 4'b0100,   // compare read entry, move it or place the value
        S_DONE = 4'b1000    // hand the result to the output register
    } state_t;

    state_t           state_reg, state_next;
    logic             act_reg, act_next;
    logic [VW-1:0]    val_reg, val_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             found_reg, found_next;
    sti_pkg::status_t st_reg, st_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg, m_data_next;

    // ram port signals
    logic          wen, ren;
    logic [AW-1:0] waddr, raddr;
    logic [VW-1:0] wdata, rdata;

    sti_pkg::cmp_res_t cmp;

    logic [CW-1:0]   idx_m1;
    logic [CW+5:0]   count_ext;
    logic            out_free;

    assign idx_m1    = idx_reg - CW'(1);
    assign count_ext = {6'b0, count_reg};
    assign out_free  = !m_valid_reg || m_tready;

    sti_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .wen   (wen),
        .waddr (waddr),
        .wdata (wdata),
        .ren   (ren),
        .raddr (raddr),
        .rdata (rdata)
    );

    sti_cmp u_cmp (
        .entry   (rdata),
        .operand (val_reg),
        .res     (cmp)
    );

    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        val_next     = val_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        found_next   = found_reg;
        st_next      = st_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wen          = 1'b0;
        waddr        = '0;
        wdata        = val_reg;
        ren          = 1'b0;
        raddr        = '0;

        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next   = s_tuser[0];
                    val_next   = s_tdata[VW-1:0];
                    found_next = 1'b0;
                    if (s_tuser[0] == sti_pkg::ACT_INSERT)
                    begin
                        if (count_reg == CAP_C)
                        begin
                            // table full: refuse without touching the ram
                            st_next    = sti_pkg::STATUS_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                if (act_reg == sti_pkg::ACT_INSERT)
                begin
                    if (idx_reg == '0)
                    begin
                        // every entry moved up: value goes to the bottom
                        wen        = 1'b1;
                        waddr      = '0;
                        count_next = count_reg + CW'(1);
                        st_next    = sti_pkg::STATUS_INSERTED;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ren        = 1'b1;
                        raddr      = idx_m1[AW-1:0];
                        state_next = S_CHK;
                    end
                end
                else
                begin
                    if (idx_reg == count_reg)
                    begin
                        if (found_reg)
                        begin
                            count_next = count_reg - CW'(1);
                            st_next    = sti_pkg::STATUS_REMOVED;
                        end
                        else
                        begin
                            st_next = sti_pkg::STATUS_NOT_FOUND;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ren        = 1'b1;
                        raddr      = idx_reg[AW-1:0];
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                if (act_reg == sti_pkg::ACT_INSERT)
                begin
                    wen   = 1'b1;
                    waddr = idx_reg[AW-1:0];
                    if (cmp.gt)
                    begin
                        // larger entry shifts up one place
                        wdata      = rdata;
                        idx_next   = idx_m1;
                        state_next = S_RD;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                        st_next    = sti_pkg::STATUS_INSERTED;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        // entries past the removed one close the gap
                        wen   = 1'b1;
                        waddr = idx_m1[AW-1:0];
                        wdata = rdata;
                    end
                    else if (cmp.eq)
                    begin
                        found_next = 1'b1;
                    end
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {count_ext[5:0], st_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // item payload and scan position
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        st_reg     <= st_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    // the table never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    // an insert compare step always has a lower neighbour inside the table
    a_insert_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK && act_reg == sti_pkg::ACT_INSERT)
        |-> (idx_reg != '0 && idx_reg <= count_reg && count_reg < CAP_C))
        else $error("insert scan outside the table");

    // a full status is only reported against a full table
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free && st_reg == sti_pkg::STATUS_FULL)
        |-> count_reg == CAP_C)
        else $error("full status with room left");

    // a new result only appears as the sequencer finishes an item
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result without a finished item");
`endif

endmodule

// ===== rtl/core/sti_ram.sv =====
// ----------------------------------------------------------------------------
// sti_ram
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sti_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                        clk,
    input  logic                        wen,
    input  logic [AW-1:0]               waddr,
    input  logic [sti_pkg::VALUE_W-1:0] wdata,
    input  logic                        ren,
    input  logic [AW-1:0]               raddr,
    output logic [sti_pkg::VALUE_W-1:0] rdata
);

    logic [sti_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [sti_pkg::VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sti_cmp.sv =====
// ----------------------------------------------------------------------------
// sti_cmp
// shared signed compare unit used by the insert and remove scans
// ----------------------------------------------------------------------------
module sti_cmp (
    input  logic signed [sti_pkg::VALUE_W-1:0] entry,
    input  logic signed [sti_pkg::VALUE_W-1:0] operand,
    output sti_pkg::cmp_res_t                  res
);

    always_comb
    begin
        res.gt = (entry > operand);
        res.eq = (entry == operand);
    end

endmodule
